[rtl/swoc_pkg.sv]
package swoc_pkg;

  localparam int WINDOW     = 100;
  localparam int SAMPLE_W   = 12;
  localparam int SLOT_W     = (WINDOW > 2) ? $clog2(WINDOW) : 1;
  localparam int SUM_W      = SAMPLE_W + SLOT_W;
  localparam int SQ_W       = 2 * SAMPLE_W + SLOT_W;
  localparam int REM_W      = SLOT_W;
  localparam int Q_W        = 2 * SAMPLE_W;
  localparam int MEAN_W     = 12;
  localparam int SPREAD_W   = 12;
  localparam int ROOT_W     = Q_W / 2;
  localparam int RT_W       = ROOT_W + 2;
  localparam int TALLY_W    = 16;
  localparam int WARM_W     = $clog2(WINDOW + 256);
  localparam int CNT_W      = $clog2(SQ_W + 1);
  localparam int SUM_MAX    = WINDOW * ((1 << SAMPLE_W) - 1);

  localparam int MULT_W     = 3;
  localparam int MINS_W     = 11;
  localparam int WEXTRA_W   = 8;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int K_W        = MULT_W + SPREAD_W;

  localparam logic [CFG_IDX_W-1:0] CFG_DEV_MULT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPREAD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_EXTRA = 2'd2;

  localparam logic [MULT_W-1:0]   DEV_MULT_RST     = 3'd2;
  localparam logic [MINS_W-1:0]   MIN_SPREAD_RST   = 11'd15;
  localparam logic [WEXTRA_W-1:0] WARMUP_EXTRA_RST = 8'd25;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_MEAN,
    ST_MUL,
    ST_VAR,
    ST_SQRT,
    ST_CMP
  } st_t;

endpackage

[rtl/swoc_if.sv]
interface swoc_in_if;
  import swoc_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface swoc_out_if;
  import swoc_pkg::*;

  logic                valid;
  logic                ready;
  logic [MEAN_W-1:0]   mean_value;
  logic [SPREAD_W-1:0] spread;
  logic                is_outlier;
  logic [TALLY_W-1:0]  disturbance_total;
  logic                warmed_up;

  modport source (output valid, output mean_value, output spread, output is_outlier,
                  output disturbance_total, output warmed_up, input ready);
  modport sink (input valid, input mean_value, input spread, input is_outlier,
                input disturbance_total, input warmed_up, output ready);
endinterface

[rtl/sliding_window_outlier_counter.sv]
// Sliding-window outlier counter. Each input beat carries one echo-width sample, which
// replaces the oldest entry of a 100-entry window held in a block memory; the block then
// returns one result beat with the truncated window mean, the floor square root of the
// truncated population variance (spread), the outlier flag, the saturating disturbance
// count and the warm-up flag. The work is done bit-serially: a one-bit-per-cycle divider
// by the window length (used for the mean and for the variance), a shift-add multiplier
// and a two-bits-per-cycle square root. Each item runs through the accept, update, mean
// division, multiply, variance division, root and compare steps in turn; a new sample is
// accepted only once the block is back in idle. A finished result waits in an output
// register, so the next sample is taken while it is pending; if the result is still not
// taken when the following one is ready, the block holds.
// Configuration writes are taken at any cycle, and are meant to be made while idle.
module sliding_window_outlier_counter (
  input  logic                            clk,
  input  logic                            rst_n,
  swoc_in_if.sink                         in_beat,
  swoc_out_if.source                      out_beat,
  input  logic                            cfg_we,
  input  logic [swoc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [swoc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import swoc_pkg::*;

  st_t state_r, state_nxt;

  logic [MULT_W-1:0]   dev_mult_r;
  logic [MINS_W-1:0]   min_spread_r;
  logic [WEXTRA_W-1:0] warmup_extra_r;

  logic [SAMPLE_W-1:0] win_mem [WINDOW];
  logic [SAMPLE_W-1:0] rd_r;
  logic [SLOT_W-1:0]   oldest_slot_r;
  logic                wrapped_r;

  logic [SAMPLE_W-1:0] x_r;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [SQ_W-1:0]     sqsum_r, sqsum_nxt;
  logic [WARM_W-1:0]   warm_r;
  logic [TALLY_W-1:0]  tally_r, tally_nxt;

  logic [CNT_W-1:0]    cnt_r;

  logic [SQ_W-1:0]     div_sh_r;
  logic [REM_W-1:0]    div_rem_r, div_rem_nxt;
  logic [Q_W-1:0]      div_q_r, div_q_nxt;
  logic [REM_W:0]      div_t;
  logic                div_ge;

  logic [MEAN_W-1:0]   mean_r;
  logic [REM_W-1:0]    mrem_r;
  logic [MEAN_W-1:0]   mul_a_r;
  logic [SUM_W:0]      mul_b_r;
  logic [SQ_W-1:0]     acc_r, acc_nxt;

  logic [Q_W-1:0]      rad_r;
  logic [RT_W-1:0]     srem_r, srem_t, srem_trial;
  logic [ROOT_W-1:0]   root_r;
  logic                sq_ge;
  logic [SPREAD_W-1:0] spread_r;

  logic [SAMPLE_W-1:0]        old_val;
  logic signed [SAMPLE_W:0]   sq_dlt;
  logic [SAMPLE_W:0]          sq_pls;
  logic signed [2*SAMPLE_W+2:0] sq_chg;

  logic [K_W-1:0]      band_k;
  logic [K_W:0]        band_hi;
  logic                outlier;
  logic                enabled;
  logic [WARM_W-1:0]   warm_limit;

  logic                res_load;
  logic                out_valid_r;
  logic [MEAN_W-1:0]   out_mean_r;
  logic [SPREAD_W-1:0] out_spread_r;
  logic                out_outlier_r;
  logic [TALLY_W-1:0]  out_total_r;
  logic                out_warm_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_mult_r     <= DEV_MULT_RST;
      min_spread_r   <= MIN_SPREAD_RST;
      warmup_extra_r <= WARMUP_EXTRA_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEV_MULT:     dev_mult_r     <= cfg_wdata[MULT_W-1:0];
        CFG_MIN_SPREAD:   min_spread_r   <= cfg_wdata[MINS_W-1:0];
        CFG_WARMUP_EXTRA: warmup_extra_r <= cfg_wdata[WEXTRA_W-1:0];
        default: ;
      endcase
    end
  end

  // Window memory: the read port always looks at the slot that is overwritten next.
  always_ff @(posedge clk) begin
    rd_r <= win_mem[oldest_slot_r];
    if (state_r == ST_UPDATE) begin
      win_mem[oldest_slot_r] <= x_r;
    end
  end

  // Until the window has wrapped once, the slot being replaced is taken as zero; the memory itself is not reset.
  assign old_val = wrapped_r ? rd_r : '0;

  // The change in the sum of squares is (x - old) * (x + old), one multiplier.
  assign sq_dlt    = $signed({1'b0, x_r}) - $signed({1'b0, old_val});
  assign sq_pls    = {1'b0, x_r} + {1'b0, old_val};
  assign sq_chg    = sq_dlt * $signed({1'b0, sq_pls});
  assign sum_nxt   = sum_r - SUM_W'(old_val) + SUM_W'(x_r);
  assign sqsum_nxt = sqsum_r + $unsigned(SQ_W'(sq_chg));

  // One restoring step of division by the window length.
  assign div_t       = {div_rem_r, div_sh_r[SQ_W-1]};
  assign div_ge      = div_t >= (REM_W+1)'(WINDOW);
  assign div_rem_nxt = div_ge ? REM_W'(div_t - (REM_W+1)'(WINDOW)) : div_t[REM_W-1:0];
  assign div_q_nxt   = {div_q_r[Q_W-2:0], div_ge};

  // MSB-first shift-add multiply of the mean by (sum + remainder).
  assign acc_nxt = {acc_r[SQ_W-2:0], 1'b0} + (mul_a_r[MEAN_W-1] ? SQ_W'(mul_b_r) : '0);

  // One digit of the square root per cycle.
  assign srem_t     = {srem_r[RT_W-3:0], rad_r[Q_W-1 -: 2]};
  assign srem_trial = {root_r, 2'b01};
  assign sq_ge      = srem_t >= srem_trial;

  // Band test and counters.
  assign band_k     = K_W'(dev_mult_r) * K_W'(spread_r);
  assign band_hi    = (K_W+1)'(mean_r) + (K_W+1)'(band_k);
  assign outlier    = (((K_W+1)'(x_r) > band_hi) ||
                       (((K_W+1)'(x_r) + (K_W+1)'(band_k)) < (K_W+1)'(mean_r))) &&
                      (spread_r > SPREAD_W'(min_spread_r));
  assign warm_limit = WARM_W'(WINDOW) + WARM_W'(warmup_extra_r);
  assign enabled    = warm_r >= warm_limit;
  assign tally_nxt  = (outlier && enabled && (tally_r != '1)) ? tally_r + 1'b1 : tally_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_beat.valid) state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_MEAN;
      ST_MEAN:   if (cnt_r == '0) state_nxt = ST_MUL;
      ST_MUL:    if (cnt_r == '0) state_nxt = ST_VAR;
      ST_VAR:    if (cnt_r == '0) state_nxt = ST_SQRT;
      ST_SQRT:   if (cnt_r == '0) state_nxt = ST_CMP;
      ST_CMP:    if (res_load) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_beat.ready = 1'b0;
    res_load      = 1'b0;
    case (state_r)
      ST_IDLE: in_beat.ready = rst_n;
      ST_CMP:  res_load      = !out_valid_r || out_beat.ready;
      default: ;
    endcase
  end

  // Window bookkeeping and running sums.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_slot_r <= '0;
      wrapped_r     <= 1'b0;
      sum_r         <= '0;
      sqsum_r       <= '0;
      warm_r        <= '0;
      tally_r       <= '0;
    end else begin
      if (state_r == ST_UPDATE) begin
        sum_r   <= sum_nxt;
        sqsum_r <= sqsum_nxt;
        if (oldest_slot_r == SLOT_W'(WINDOW - 1)) begin
          oldest_slot_r <= '0;
          wrapped_r     <= 1'b1;
        end else begin
          oldest_slot_r <= oldest_slot_r + 1'b1;
        end
      end
      if (res_load) begin
        tally_r <= tally_nxt;
        if (warm_r < warm_limit) begin
          warm_r <= warm_r + 1'b1;
        end
      end
    end
  end

  // Serial datapath: divider, multiplier and square root share one step counter.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_beat.valid) begin
          x_r <= in_beat.sample;
        end
      end
      ST_UPDATE: begin
        div_sh_r  <= {sum_nxt, (SQ_W-SUM_W)'(0)};
        div_rem_r <= '0;
        div_q_r   <= '0;
        cnt_r     <= CNT_W'(SUM_W);
      end
      ST_MEAN: begin
        if (cnt_r != '0) begin
          div_sh_r  <= {div_sh_r[SQ_W-2:0], 1'b0};
          div_rem_r <= div_rem_nxt;
          div_q_r   <= div_q_nxt;
          cnt_r     <= cnt_r - 1'b1;
        end else begin
          mean_r  <= div_q_r[MEAN_W-1:0];
          mrem_r  <= div_rem_r;
          mul_a_r <= div_q_r[MEAN_W-1:0];
          mul_b_r <= (SUM_W+1)'(sum_r) + (SUM_W+1)'(div_rem_r);
          acc_r   <= '0;
          cnt_r   <= CNT_W'(MEAN_W);
        end
      end
      ST_MUL: begin
        if (cnt_r != '0) begin
          acc_r   <= acc_nxt;
          mul_a_r <= {mul_a_r[MEAN_W-2:0], 1'b0};
          cnt_r   <= cnt_r - 1'b1;
        end else begin
          // Sum of squared deviations = sum of squares - mean * (sum + remainder).
          div_sh_r  <= sqsum_r - acc_r;
          div_rem_r <= '0;
          div_q_r   <= '0;
          cnt_r     <= CNT_W'(SQ_W);
        end
      end
      ST_VAR: begin
        if (cnt_r != '0) begin
          div_sh_r  <= {div_sh_r[SQ_W-2:0], 1'b0};
          div_rem_r <= div_rem_nxt;
          div_q_r   <= div_q_nxt;
          cnt_r     <= cnt_r - 1'b1;
        end else begin
          rad_r  <= div_q_r;
          srem_r <= '0;
          root_r <= '0;
          cnt_r  <= CNT_W'(Q_W / 2);
        end
      end
      ST_SQRT: begin
        if (cnt_r != '0) begin
          rad_r  <= {rad_r[Q_W-3:0], 2'b00};
          srem_r <= sq_ge ? srem_t - srem_trial : srem_t;
          root_r <= {root_r[ROOT_W-2:0], sq_ge};
          cnt_r  <= cnt_r - 1'b1;
        end else begin
          spread_r <= SPREAD_W'(root_r);
        end
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_beat.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_mean_r    <= mean_r;
      out_spread_r  <= spread_r;
      out_outlier_r <= outlier;
      out_total_r   <= tally_nxt;
      out_warm_r    <= enabled;
    end
  end

  assign out_beat.valid             = out_valid_r;
  assign out_beat.mean_value        = out_mean_r;
  assign out_beat.spread            = out_spread_r;
  assign out_beat.is_outlier        = out_outlier_r;
  assign out_beat.disturbance_total = out_total_r;
  assign out_beat.warmed_up         = out_warm_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat.valid && in_beat.ready) |=> (state_r == ST_UPDATE))
    else $error("accepted beat did not start an update");

  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (32'(sum_r) <= 32'(SUM_MAX)))
    else $error("window sum out of range");

  a_mean_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |->
      (40'(mean_r) * 40'(WINDOW) + 40'(mrem_r) == 40'(sum_r)))
    else $error("mean division inconsistent with window sum");

  a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP) |->
      ((32'(spread_r) * 32'(spread_r) <= 32'(div_q_r)) &&
       ((32'(spread_r) + 32'd1) * (32'(spread_r) + 32'd1) > 32'(div_q_r))))
    else $error("spread is not the floor square root of the variance");

endmodule
